// ===== hw/rtl/bfs_reachability_engine_macros.svh =====
// Assertion macros shared by the reachability engine modules
`ifndef BFS_REACHABILITY_ENGINE_MACROS_SVH
`define BFS_REACHABILITY_ENGINE_MACROS_SVH

// Check cons in the same cycle as ante
`define BFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante
`define BFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bfs_pkg.sv =====
// Shared types, codes and constants of the reachability engine
package bfs_pkg;

    localparam int NODES_DEF = 64;
    localparam int FIELD_W   = 6;
    localparam int CFG_W     = 7;
    localparam int OP_W      = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;
    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_RUN   = 2'd2
    } op_t;

    typedef struct packed {
        logic capture;
        logic clear_graph;
        logic add_write;
        logic run_init;
        logic deq;
        logic adj_read;
        logic fetch;
        logic scan_step;
        logic emit_load;
        logic emit_next;
    } ctrl_cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic start_ok;
        logic pending_empty;
        logic queue_done;
        logic emit_last;
    } ctrl_status_t;

endpackage

// ===== hw/rtl/bfs_ram.sv =====
// Generic single write port, single registered read port RAM
module bfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bfs_ctrl.sv =====
// Controller state machine of the reachability engine
`include "bfs_reachability_engine_macros.svh"

module bfs_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [bfs_pkg::OP_W-1:0] s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output bfs_pkg::ctrl_cmd_t     cmd,
    input  bfs_pkg::ctrl_status_t  status
);

    import bfs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_RUN_INIT,
        ST_DEQ,
        ST_ADJ,
        ST_FETCH,
        ST_SCAN,
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    case (op_t'(s_tuser))
                        OP_CLEAR: cmd.clear_graph = 1'b1;
                        OP_ADD:   state_next = ST_ADD_RD;
                        OP_RUN:   state_next = ST_RUN_INIT;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_RD: state_next = ST_ADD_WR;
            ST_ADD_WR: begin
                cmd.add_write = status.edge_ok;
                state_next    = ST_IDLE;
            end
            ST_RUN_INIT: begin
                cmd.run_init = 1'b1;
                state_next   = status.start_ok ? ST_DEQ : ST_LOAD;
            end
            ST_DEQ: begin
                cmd.deq    = 1'b1;
                state_next = ST_ADJ;
            end
            ST_ADJ: begin
                cmd.adj_read = 1'b1;
                state_next   = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!status.pending_empty) begin
                    cmd.scan_step = 1'b1;
                end else if (status.queue_done) begin
                    state_next = ST_LOAD;
                end else begin
                    state_next = ST_DEQ;
                end
            end
            ST_LOAD: begin
                cmd.emit_load = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.emit_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= (state_next == ST_EMIT);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    `BFS_ASSERT_NOW(a_valid_only_emit, aclk, aresetn, m_tvalid_reg, state_reg == ST_EMIT, "result valid outside emit")
    `BFS_ASSERT_NEXT(a_last_ends_run, aclk, aresetn, m_tvalid_reg && m_tready && status.emit_last, (state_reg == ST_IDLE) && !m_tvalid_reg, "run did not end after last result")

endmodule

// ===== hw/rtl/bfs_datapath.sv =====
// Datapath: adjacency RAM, work queue RAM, visited marks and result registers
`include "bfs_reachability_engine_macros.svh"

module bfs_datapath #(
    parameter int NODES = bfs_pkg::NODES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_fire,
    input  logic [bfs_pkg::CFG_W-1:0]     cfg_data,
    input  logic [bfs_pkg::S_TDATA_W-1:0] s_tdata,
    input  bfs_pkg::ctrl_cmd_t            cmd,
    output bfs_pkg::ctrl_status_t         status,
    output logic [bfs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    import bfs_pkg::*;

    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = $clog2(NODES + 1);

    logic [CFG_W-1:0]   node_count_reg;
    logic [CNT_W-1:0]   n_eff;
    logic [NODES-1:0]   keep;

    logic [FIELD_W-1:0] src_reg, dst_reg, start_reg;
    logic [NODES-1:0]   row_valid_reg;
    logic               row_valid_q_reg;
    logic [NODES-1:0]   visited_reg;
    logic [NODES-1:0]   pending_reg;
    logic [CNT_W-1:0]   head_reg, tail_reg;

    logic [IDX_W-1:0]   out_idx_reg;
    logic               out_reached_reg;
    logic               out_last_reg;

    logic [IDX_W-1:0]   adj_raddr;
    logic [NODES-1:0]   adj_rdata;
    logic               adj_we;
    logic [NODES-1:0]   adj_wdata;
    logic [NODES-1:0]   adj_row;

    logic               q_we;
    logic [IDX_W-1:0]   q_waddr, q_wdata, q_rdata;

    logic [NODES-1:0]   low_bit;
    logic [IDX_W-1:0]   low_idx;
    logic [IDX_W-1:0]   next_idx;
    logic [IDX_W-1:0]   start_idx;

    always_comb begin
        if (node_count_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (node_count_reg > CFG_W'(NODES)) begin
            n_eff = CNT_W'(NODES);
        end else begin
            n_eff = CNT_W'(node_count_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            keep[i] = (CFG_W'(i) < CFG_W'(n_eff));
        end
    end

    always_comb begin
        low_bit = pending_reg & (~pending_reg + NODES'(1));
        low_idx = '0;
        for (int i = 0; i < NODES; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | IDX_W'(i);
            end
        end
    end

    assign start_idx = start_reg[IDX_W-1:0];
    assign next_idx  = out_idx_reg + IDX_W'(1);
    assign adj_raddr = cmd.adj_read ? q_rdata : src_reg[IDX_W-1:0];
    assign adj_row   = row_valid_q_reg ? adj_rdata : '0;
    assign adj_we    = cmd.add_write;
    assign adj_wdata = adj_row | (NODES'(1) << dst_reg[IDX_W-1:0]);

    assign q_we    = cmd.scan_step || (cmd.run_init && status.start_ok);
    assign q_waddr = cmd.scan_step ? tail_reg[IDX_W-1:0] : '0;
    assign q_wdata = cmd.scan_step ? low_idx : start_idx;

    bfs_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj_ram (
        .clk   (aclk),
        .we    (adj_we),
        .waddr (src_reg[IDX_W-1:0]),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    bfs_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_queue_ram (
        .clk   (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg[IDX_W-1:0]),
        .rdata (q_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RST;
            row_valid_reg  <= '0;
            visited_reg    <= '0;
            pending_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
        end else begin
            if (cfg_fire) begin
                node_count_reg <= cfg_data;
            end
            if (cmd.clear_graph) begin
                row_valid_reg <= '0;
            end else if (cmd.add_write) begin
                row_valid_reg[src_reg[IDX_W-1:0]] <= 1'b1;
            end
            if (cmd.run_init) begin
                head_reg    <= '0;
                tail_reg    <= status.start_ok ? CNT_W'(1) : '0;
                visited_reg <= status.start_ok ? (NODES'(1) << start_idx) : '0;
            end else if (cmd.scan_step) begin
                tail_reg    <= tail_reg + CNT_W'(1);
                visited_reg <= visited_reg | low_bit;
                pending_reg <= pending_reg & ~low_bit;
            end else if (cmd.fetch) begin
                pending_reg <= adj_row & keep & ~visited_reg;
            end
            if (cmd.deq) begin
                head_reg <= head_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_valid_q_reg <= row_valid_reg[adj_raddr];
        if (cmd.capture) begin
            src_reg   <= s_tdata[FIELD_W-1:0];
            dst_reg   <= s_tdata[2*FIELD_W-1:FIELD_W];
            start_reg <= s_tdata[3*FIELD_W-1:2*FIELD_W];
        end
        if (cmd.emit_load) begin
            out_idx_reg     <= '0;
            out_reached_reg <= visited_reg[0];
            out_last_reg    <= (n_eff == CNT_W'(1));
        end else if (cmd.emit_next) begin
            out_idx_reg     <= next_idx;
            out_reached_reg <= visited_reg[next_idx];
            out_last_reg    <= (CNT_W'(next_idx) == n_eff - CNT_W'(1));
        end
    end

    assign status.edge_ok = (src_reg != dst_reg)
                         && (CFG_W'(src_reg) < CFG_W'(n_eff))
                         && (CFG_W'(dst_reg) < CFG_W'(n_eff));
    assign status.start_ok      = (CFG_W'(start_reg) < CFG_W'(n_eff));
    assign status.pending_empty = (pending_reg == '0);
    assign status.queue_done    = (head_reg == tail_reg);
    assign status.emit_last     = out_last_reg;

    assign m_tdata = {1'b0, out_reached_reg, FIELD_W'(out_idx_reg)};
    assign m_tlast = out_last_reg;

    `BFS_ASSERT_NOW(a_marks_match_tail, aclk, aresetn, 1'b1, $countones(visited_reg) == int'(tail_reg), "visited count differs from queue tail")
    `BFS_ASSERT_NOW(a_pending_unvisited, aclk, aresetn, 1'b1, (pending_reg & visited_reg) == '0, "pending vertex already visited")

endmodule

// ===== hw/rtl/bfs_reachability_engine.sv =====
// Top level of the breadth-first search reachability engine
// Clear graph acts on acceptance; add edge goes through accept, row read and row write.
// Run: init; per reached vertex dequeue, row read, fetch, a scan step per new vertex; load;
// the loop is set by the registered read of the adjacency RAM and the single queue write port.
// Results then follow one per cycle while m_tready is high; input is taken again after the last.
// Synchronous active-low reset empties the graph, clears the marks and sets node_count to 64.
module bfs_reachability_engine #(
    parameter int NODES = bfs_pkg::NODES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfs_pkg::CFG_W-1:0]     cfg_data,  // node_count
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bfs_pkg::S_TDATA_W-1:0] s_tdata,   // source_node, dest_node, start_node
    input  logic [bfs_pkg::OP_W-1:0]      s_tuser,   // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bfs_pkg::M_TDATA_W-1:0] m_tdata,   // node_index, reached
    output logic                          m_tlast
);

    import bfs_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    bfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    bfs_datapath #(.NODES(NODES)) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_fire (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== test/bfs_reachability_checker.sv =====
// Checker for the reachability engine: predicts search results and compares them
`timescale 1ns / 100ps

module bfs_reachability_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [bfs_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [bfs_pkg::S_TDATA_W-1:0] s_tdata,   // source_node, dest_node, start_node
    input  logic [bfs_pkg::OP_W-1:0]      s_tuser,   // op
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [bfs_pkg::M_TDATA_W-1:0] m_tdata,   // node_index, reached
    input  logic                          m_tlast,
    output int                            mismatch_count,
    output int                            reports_pending
);
    import bfs_pkg::*;

    localparam int NODES = NODES_DEF;

    typedef struct packed {
        logic [FIELD_W-1:0] node;
        logic               reached;
        logic               last;
    } vertex_report_t;

    logic [CFG_W-1:0] node_count;
    logic [63:0]      adjacency [NODES];
    vertex_report_t   report_q [$];
    int               fail_total;

    function automatic int active_nodes();
        int n;
        n = node_count;
        if (n < 1) n = 1;
        if (n > NODES) n = NODES;
        return n;
    endfunction

    function automatic logic [63:0] reachable_set(int start, int n);
        logic [63:0] keep;
        logic [63:0] marks;
        logic [63:0] fresh;
        int          frontier [$];
        int          u;
        int          v;
        keep  = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        marks = '0;
        if (start >= n) return marks;
        marks[start] = 1'b1;
        frontier.push_back(start);
        while (frontier.size() > 0) begin
            u     = frontier.pop_front();
            fresh = adjacency[u] & keep & ~marks;
            for (v = 0; v < n; v++) begin
                if (fresh[v]) begin
                    marks[v] = 1'b1;
                    frontier.push_back(v);
                end
            end
        end
        return marks;
    endfunction

    always @(posedge aclk) begin : observe
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] dst;
        logic [FIELD_W-1:0] start;
        logic [63:0]        marks;
        vertex_report_t     want;
        vertex_report_t     got;
        int                 n;
        int                 i;
        if (!aresetn) begin
            node_count = NODE_COUNT_RST;
            for (i = 0; i < NODES; i++) adjacency[i] = '0;
            report_q.delete();
            fail_total = 0;
        end else begin
            if (cfg_valid && cfg_ready) node_count = cfg_data;

            if (m_tvalid && m_tready) begin
                got.node    = m_tdata[FIELD_W-1:0];
                got.reached = m_tdata[FIELD_W];
                got.last    = m_tlast;
                if (report_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: unexpected result node %0d reached %0b last %0b",
                                 $time, got.node, got.reached, got.last);
                end else begin
                    want = report_q.pop_front();
                    if (got.node != want.node || got.reached != want.reached
                            || got.last != want.last) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display({"%0t: mismatch: expected node %0d reached %0b last %0b,",
                                      " got node %0d reached %0b last %0b"},
                                     $time, want.node, want.reached, want.last,
                                     got.node, got.reached, got.last);
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                src   = s_tdata[FIELD_W-1:0];
                dst   = s_tdata[2*FIELD_W-1:FIELD_W];
                start = s_tdata[3*FIELD_W-1:2*FIELD_W];
                n     = active_nodes();
                case (s_tuser)
                    OP_CLEAR: begin
                        for (i = 0; i < NODES; i++) adjacency[i] = '0;
                    end
                    OP_ADD: begin
                        if (src != dst && src < n && dst < n) adjacency[src][dst] = 1'b1;
                    end
                    OP_RUN: begin
                        marks = reachable_set(start, n);
                        for (i = 0; i < n; i++) begin
                            want.node    = i[FIELD_W-1:0];
                            want.reached = marks[i];
                            want.last    = (i == n - 1);
                            report_q.push_back(want);
                        end
                    end
                    default: ;
                endcase
            end
        end
        mismatch_count  <= fail_total;
        reports_pending <= report_q.size();
    end

endmodule

// ===== test/tb_bfs_reachability_engine.sv =====
// Testbench top for the reachability engine: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_bfs_reachability_engine;
    import bfs_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RUN_LIMIT    = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 16;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // source_node, dest_node, start_node
    logic [OP_W-1:0]      s_tuser;   // op
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // node_index, reached
    logic                 m_tlast;

    int mismatch_count;
    int reports_pending;
    int cycle_count;
    bit src_steady;
    bit sink_steady;
    bit hold_request;
    bit hold_served;

    bfs_reachability_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    bfs_reachability_checker reach_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    task automatic send_request(logic [OP_W-1:0] op, int src, int dst, int start);
        int gap;
        gap = src_steady ? 0 : idle_span();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 3*FIELD_W){1'b0}},
                     FIELD_W'(start), FIELD_W'(dst), FIELD_W'(src)};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (reports_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_node_count(int value);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int setting);
        int n;
        int r;
        int s;
        int k;
        n = (setting < 1) ? 1 : ((setting > 64) ? 64 : setting);
        write_node_count(setting);
        send_request(OP_CLEAR, $urandom, $urandom, $urandom);
        for (k = 0; k < PHASE_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, n - 1);
            if (r < 20)
                send_request(OP_ADD, s, (s + 1) % n, $urandom);
            else if (r < 50)
                send_request(OP_ADD, s, $urandom_range(0, n - 1), $urandom);
            else if (r < 62)
                send_request(OP_ADD, $urandom, $urandom, $urandom);
            else if (r < 84)
                send_request(OP_RUN, $urandom, $urandom, s);
            else if (r < 88)
                send_request(OP_RUN, $urandom, $urandom, $urandom);
            else if (r < 94)
                send_request(OP_CLEAR, $urandom, $urandom, $urandom);
            else
                send_request(OP_SPARE, $urandom, $urandom, $urandom);
        end
        settle();
    endtask

    initial begin : sink
        int stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (sink_steady) begin
                m_tready <= 1'b1;
            end else begin
                stall_left = idle_span();
                m_tready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_CLEAR;
        src_steady   = 1'b0;
        sink_steady  = 1'b0;
        hold_request = 1'b0;
        hold_served  = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(OP_RUN, 0, 0, 0);
        send_request(OP_ADD, 0, 63, 0);
        send_request(OP_ADD, 63, 5, 0);
        send_request(OP_ADD, 5, 0, 0);
        send_request(OP_ADD, 7, 7, 0);
        send_request(OP_ADD, 1, 2, 0);
        send_request(OP_RUN, 0, 0, 0);
        send_request(OP_RUN, 0, 0, 63);
        send_request(OP_RUN, 0, 0, 7);
        send_request(OP_SPARE, 63, 63, 63);
        send_request(OP_CLEAR, 0, 0, 0);
        send_request(OP_RUN, 0, 0, 63);
        send_request(OP_ADD, 10, 2, 0);
        send_request(OP_ADD, 2, 10, 0);
        send_request(OP_ADD, 2, 3, 0);
        settle();

        // shrink the graph below some of the stale edges
        write_node_count(4);
        send_request(OP_ADD, 0, 5, 0);
        send_request(OP_ADD, 3, 1, 0);
        send_request(OP_RUN, 0, 0, 2);
        send_request(OP_RUN, 0, 0, 4);
        send_request(OP_RUN, 0, 0, 63);
        settle();
        write_node_count(1);
        send_request(OP_RUN, 0, 0, 0);
        send_request(OP_RUN, 0, 0, 1);
        settle();
        write_node_count(0);
        send_request(OP_RUN, 0, 0, 0);
        settle();
        write_node_count(127);
        send_request(OP_RUN, 0, 0, 2);
        settle();

        hold_request = 1'b1;
        random_phase(64);
        random_phase(9);
        random_phase(1);
        random_phase($urandom_range(65, 127));
        random_phase(33);
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        random_phase(64);
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        random_phase(0);
        random_phase($urandom_range(2, 63));

        if (mismatch_count == 0 && reports_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
